### sv/sps_pkg.sv
// ============================================================================
// sps_pkg - shared types and constants of the shaped parameter smoother
// Register map codes, curve codes, configuration struct and the
// reciprocal table used for division by small constants.
// ============================================================================
`default_nettype none

package sps_pkg;

    // field widths
    localparam int VAL_W    = 24;
    localparam int DT_W     = 20;
    localparam int SMOOTH_W = 17;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;

    // fixed point constants
    localparam logic [14:0] Q14_ONE   = 15'd16384;
    localparam logic [14:0] Q14_HALF  = 15'd8192;
    localparam logic [16:0] Q16_ONE   = 17'd65536;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [16:0] RESP_MIN  = 17'd655;
    localparam logic [5:0]  ANGLE_DIV = 6'd30;

    // register indexes
    localparam logic [2:0] REG_CURVE    = 3'd0;
    localparam logic [2:0] REG_UNIPOLAR = 3'd1;
    localparam logic [2:0] REG_INVERTED = 3'd2;
    localparam logic [2:0] REG_ANGLE    = 3'd3;
    localparam logic [2:0] REG_MIN      = 3'd4;
    localparam logic [2:0] REG_MAX      = 3'd5;
    localparam logic [2:0] REG_SMOOTH   = 3'd6;

    // response curve codes
    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_EASE   = 2'd1;
    localparam logic [1:0] CURVE_SQRT   = 2'd2;
    localparam logic [1:0] CURVE_SNAP   = 2'd3;

    typedef struct packed {
        logic [1:0]                  curve_mode;
        logic                        unipolar;
        logic                        inverted;
        logic                        angle_source;
        logic signed [VAL_W-1:0]     min_value;
        logic signed [VAL_W-1:0]     max_value;
        logic [SMOOTH_W-1:0]         smoothing;
    } cfg_t;

    typedef struct packed {
        logic busy;
    } seq_status_t;

    // floor(2^31 / d) for d in 1..32; quotient estimate is low by at most one
    function automatic logic [31:0] recip_q31(input logic [5:0] d);
        logic [31:0] r;
        unique case (d)
            6'd1:    r = 32'd2147483648;
            6'd2:    r = 32'd1073741824;
            6'd3:    r = 32'd715827882;
            6'd4:    r = 32'd536870912;
            6'd5:    r = 32'd429496729;
            6'd6:    r = 32'd357913941;
            6'd7:    r = 32'd306783378;
            6'd8:    r = 32'd268435456;
            6'd9:    r = 32'd238609294;
            6'd10:   r = 32'd214748364;
            6'd11:   r = 32'd195225786;
            6'd12:   r = 32'd178956970;
            6'd13:   r = 32'd165191049;
            6'd14:   r = 32'd153391689;
            6'd15:   r = 32'd143165576;
            6'd16:   r = 32'd134217728;
            6'd17:   r = 32'd126322567;
            6'd18:   r = 32'd119304647;
            6'd19:   r = 32'd113025455;
            6'd20:   r = 32'd107374182;
            6'd21:   r = 32'd102261126;
            6'd22:   r = 32'd97612893;
            6'd23:   r = 32'd93368854;
            6'd24:   r = 32'd89478485;
            6'd25:   r = 32'd85899345;
            6'd26:   r = 32'd82595524;
            6'd27:   r = 32'd79536431;
            6'd28:   r = 32'd76695844;
            6'd29:   r = 32'd74051160;
            6'd30:   r = 32'd71582788;
            6'd31:   r = 32'd69273666;
            6'd32:   r = 32'd67108864;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/sps_cfg.sv
// ============================================================================
// sps_cfg - configuration register file
// APB-style write/read port holding the curve, mapping and smoothing setup.
// ============================================================================
`default_nettype none

module sps_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output sps_pkg::cfg_t     cfg
);
    import sps_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.curve_mode   <= CURVE_LINEAR;
            cfg_reg.unipolar     <= 1'b0;
            cfg_reg.inverted     <= 1'b0;
            cfg_reg.angle_source <= 1'b0;
            cfg_reg.min_value    <= -24'sd491520;
            cfg_reg.max_value    <= 24'sd491520;
            cfg_reg.smoothing    <= 17'd22938;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CURVE:    cfg_reg.curve_mode   <= pwdata[1:0];
                REG_UNIPOLAR: cfg_reg.unipolar     <= pwdata[0];
                REG_INVERTED: cfg_reg.inverted     <= pwdata[0];
                REG_ANGLE:    cfg_reg.angle_source <= pwdata[0];
                REG_MIN:      cfg_reg.min_value    <= $signed(pwdata[VAL_W-1:0]);
                REG_MAX:      cfg_reg.max_value    <= $signed(pwdata[VAL_W-1:0]);
                REG_SMOOTH:   cfg_reg.smoothing    <= pwdata[SMOOTH_W-1:0];
                default:      ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            REG_CURVE:    prdata = {30'd0, cfg_reg.curve_mode};
            REG_UNIPOLAR: prdata = {31'd0, cfg_reg.unipolar};
            REG_INVERTED: prdata = {31'd0, cfg_reg.inverted};
            REG_ANGLE:    prdata = {31'd0, cfg_reg.angle_source};
            REG_MIN:      prdata = {8'd0, cfg_reg.min_value};
            REG_MAX:      prdata = {8'd0, cfg_reg.max_value};
            REG_SMOOTH:   prdata = {15'd0, cfg_reg.smoothing};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### sv/sps_mul.sv
// ============================================================================
// sps_mul - shared signed multiplier
// 33x33 signed multiply with a registered product, used by every multiplying step.
// ============================================================================
`default_nettype none

module sps_mul (
    input  wire logic                              clk,
    input  wire logic signed [sps_pkg::MUL_W-1:0]  mul_a,
    input  wire logic signed [sps_pkg::MUL_W-1:0]  mul_b,
    output logic signed [sps_pkg::PROD_W-1:0]      mul_p
);
    import sps_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign mul_p = prod_reg;

endmodule

`default_nettype wire

### sv/sps_seq.sv
// ============================================================================
// sps_seq - sequencer of the smoother
// Steps one request through divide (angle source only), curve, range mapping,
// exponential and update on the shared multiplier, taking no new request until done.
// ============================================================================
`default_nettype none

module sps_seq #(
    parameter int EXP_ITERATIONS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sps_pkg::cfg_t                     cfg,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [sps_pkg::VAL_W-1:0]  sample,
    input  wire logic [sps_pkg::DT_W-1:0]          delta_time,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [sps_pkg::VAL_W-1:0]       smoothed_value,
    output logic signed [sps_pkg::MUL_W-1:0]       mul_a,
    output logic signed [sps_pkg::MUL_W-1:0]       mul_b,
    input  wire logic signed [sps_pkg::PROD_W-1:0] mul_p,
    output sps_pkg::seq_status_t                   status
);
    import sps_pkg::*;

    localparam int IW = $clog2(EXP_ITERATIONS + 1);
    localparam logic [IW-1:0] I_LAST = IW'(EXP_ITERATIONS);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DV1   = 5'd1;
    localparam logic [4:0] S_DV2   = 5'd2;
    localparam logic [4:0] S_DV3   = 5'd3;
    localparam logic [4:0] S_SHP   = 5'd4;
    localparam logic [4:0] S_EZ1   = 5'd5;
    localparam logic [4:0] S_EZ2   = 5'd6;
    localparam logic [4:0] S_SQ    = 5'd7;
    localparam logic [4:0] S_SQC   = 5'd8;
    localparam logic [4:0] S_MAP   = 5'd9;
    localparam logic [4:0] S_TGT   = 5'd10;
    localparam logic [4:0] S_XC    = 5'd11;
    localparam logic [4:0] S_EXM   = 5'd12;
    localparam logic [4:0] S_EXD   = 5'd13;
    localparam logic [4:0] S_CLAMP = 5'd14;
    localparam logic [4:0] S_ESQ   = 5'd15;
    localparam logic [4:0] S_ESQC  = 5'd16;
    localparam logic [4:0] S_UPD   = 5'd17;
    localparam logic [4:0] S_FIN   = 5'd18;

    logic [4:0]               state_reg, state_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0]  out_data_reg, out_data_next;
    logic signed [VAL_W-1:0]  cur_reg, cur_next;

    // working registers
    logic [DT_W-1:0]          dt_reg, dt_next;
    logic                     neg_reg, neg_next;
    logic [30:0]              t_reg, t_next;
    logic [30:0]              q_reg, q_next;
    logic [5:0]               den_reg, den_next;
    logic                     dvexp_reg, dvexp_next;
    logic [14:0]              mag_reg, mag_next;
    logic [14:0]              r_reg, r_next;
    logic [3:0]               bit_reg, bit_next;
    logic signed [VAL_W:0]    target_reg, target_next;
    logic [19:0]              y_reg, y_next;
    logic [30:0]              term_reg, term_next;
    logic signed [32:0]       sum_reg, sum_next;
    logic [IW-1:0]            i_reg, i_next;
    logic [30:0]              p_reg, p_next;
    logic [1:0]               cnt_reg, cnt_next;
    logic [16:0]              alpha_reg, alpha_next;

    // datapath helpers
    logic                     accept;
    logic [VAL_W-1:0]         sample_abs;
    logic signed [17:0]       resp_raw;
    logic [16:0]              resp;
    logic [20:0]              k_rate;
    logic [14:0]              trial;
    logic signed [15:0]       n_s, n_val;
    logic signed [16:0]       n_bias;
    logic [14:0]              unit;
    logic signed [VAL_W:0]    range_span;
    logic signed [VAL_W:0]    err;
    logic [30:0]              rem;
    logic [30:0]              q_fix;
    logic [24:0]              x_val;
    logic signed [PROD_W-1:0] tgt_sh, upd_sh;
    logic signed [VAL_W-1:0]  cur_new;
    logic                     out_free;

    assign accept         = in_valid & (state_reg == S_IDLE);
    assign in_stall       = (state_reg != S_IDLE);
    assign status.busy    = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign smoothed_value = out_data_reg;
    assign out_free       = ~out_valid_reg | ~out_stall;

    assign sample_abs = sample[VAL_W-1] ? VAL_W'(-sample) : VAL_W'(sample);

    // rate constant k = 4 + 26 * max(0.01, 1 - smoothing), Q16
    assign resp_raw = $signed({1'b0, Q16_ONE}) - $signed({1'b0, cfg.smoothing});
    assign resp     = (resp_raw < $signed({1'b0, RESP_MIN})) ? RESP_MIN : resp_raw[16:0];
    assign k_rate   = 21'(22'(resp) * 22'd26) + 21'd262144;

    // bitwise root trial
    assign trial = r_reg | (15'd1 << bit_reg);

    // sign, inversion and unit mapping
    assign n_s    = $signed({1'b0, r_reg});
    assign n_val  = (neg_reg ^ cfg.inverted) ? -n_s : n_s;
    assign n_bias = 17'(n_val) + $signed({2'b0, Q14_ONE});
    assign unit   = cfg.unipolar ? (n_val[15] ? 15'd0 : n_val[14:0]) : n_bias[15:1];
    assign range_span = 25'(cfg.max_value) - 25'(cfg.min_value);

    // divide correction: estimate is low by at most one
    assign rem   = t_reg - mul_p[30:0];
    assign q_fix = q_reg + 31'((rem >= 31'(den_reg)) ? 1 : 0);

    assign x_val  = mul_p[40:16];
    assign tgt_sh = mul_p >>> 14;
    assign upd_sh = mul_p >>> 16;
    assign err    = target_reg - 25'(cur_reg);
    assign cur_new = cur_reg + upd_sh[VAL_W-1:0];

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DV1:
            begin
                mul_a = $signed(MUL_W'(t_reg));
                mul_b = $signed(MUL_W'(recip_q31(den_reg)));
            end
            S_DV2:
            begin
                mul_a = $signed(MUL_W'(mul_p[61:31]));
                mul_b = $signed(MUL_W'(den_reg));
            end
            S_SHP:
            begin
                mul_a = $signed(MUL_W'(mag_reg));
                mul_b = $signed(MUL_W'(mag_reg));
            end
            S_EZ1:
            begin
                mul_a = $signed(MUL_W'(mul_p[28:14]));
                mul_b = $signed(MUL_W'(17'd49152 - {1'b0, mag_reg, 1'b0}));
            end
            S_SQ:
            begin
                mul_a = $signed(MUL_W'(trial));
                mul_b = $signed(MUL_W'(trial));
            end
            S_MAP:
            begin
                mul_a = $signed(MUL_W'(unit));
                mul_b = MUL_W'(range_span);
            end
            S_TGT:
            begin
                mul_a = $signed(MUL_W'(dt_reg));
                mul_b = $signed(MUL_W'(k_rate));
            end
            S_EXM:
            begin
                mul_a = $signed(MUL_W'(term_reg));
                mul_b = $signed(MUL_W'(y_reg));
            end
            S_ESQ:
            begin
                mul_a = $signed(MUL_W'(p_reg));
                mul_b = $signed(MUL_W'(p_reg));
            end
            S_UPD, S_FIN:
            begin
                mul_a = MUL_W'(err);
                mul_b = $signed(MUL_W'(alpha_reg));
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & out_stall;
        out_data_next  = out_data_reg;
        cur_next       = cur_reg;
        dt_next        = dt_reg;
        neg_next       = neg_reg;
        t_next         = t_reg;
        q_next         = q_reg;
        den_next       = den_reg;
        dvexp_next     = dvexp_reg;
        mag_next       = mag_reg;
        r_next         = r_reg;
        bit_next       = bit_reg;
        target_next    = target_reg;
        y_next         = y_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        i_next         = i_reg;
        p_next         = p_reg;
        cnt_next       = cnt_reg;
        alpha_next     = alpha_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dt_next  = delta_time;
                    neg_next = sample[VAL_W-1];
                    if (cfg.angle_source)
                    begin
                        t_next     = 31'(sample_abs);
                        den_next   = ANGLE_DIV;
                        dvexp_next = 1'b0;
                        state_next = S_DV1;
                    end
                    else
                    begin
                        mag_next   = (sample_abs >= 24'(Q14_ONE)) ? Q14_ONE
                                                                  : sample_abs[14:0];
                        state_next = S_SHP;
                    end
                end
            end
            S_DV1: state_next = S_DV2;
            S_DV2:
            begin
                q_next     = mul_p[61:31];
                state_next = S_DV3;
            end
            S_DV3:
            begin
                if (dvexp_reg)
                begin
                    term_next = q_fix;
                    sum_next  = i_reg[0] ? sum_reg - $signed(33'(q_fix))
                                         : sum_reg + $signed(33'(q_fix));
                    if (i_reg == I_LAST)
                        state_next = S_CLAMP;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_EXM;
                    end
                end
                else
                begin
                    mag_next   = (q_fix >= 31'(Q14_ONE)) ? Q14_ONE : q_fix[14:0];
                    state_next = S_SHP;
                end
            end
            S_SHP:
            begin
                unique case (cfg.curve_mode)
                    CURVE_LINEAR:
                    begin
                        r_next     = mag_reg;
                        state_next = S_MAP;
                    end
                    CURVE_EASE: state_next = S_EZ1;
                    CURVE_SQRT:
                    begin
                        r_next     = 15'd0;
                        bit_next   = 4'd14;
                        state_next = S_SQ;
                    end
                    CURVE_SNAP:
                    begin
                        r_next     = (mag_reg >= Q14_HALF) ? Q14_ONE : 15'd0;
                        state_next = S_MAP;
                    end
                    default: ;
                endcase
            end
            S_EZ1: state_next = S_EZ2;
            S_EZ2:
            begin
                r_next     = mul_p[28:14];
                state_next = S_MAP;
            end
            S_SQ: state_next = S_SQC;
            S_SQC:
            begin
                if (mul_p[29:0] <= {1'b0, mag_reg, 14'd0})
                    r_next = trial;
                if (bit_reg == 4'd0)
                    state_next = S_MAP;
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_SQ;
                end
            end
            S_MAP: state_next = S_TGT;
            S_TGT:
            begin
                target_next = 25'(cfg.min_value) + tgt_sh[VAL_W:0];
                state_next  = S_XC;
            end
            S_XC:
            begin
                // exponent of sixteen or more: full step to the target
                if (x_val[24:20] != 5'd0)
                begin
                    alpha_next = Q16_ONE;
                    state_next = S_UPD;
                end
                else
                begin
                    y_next     = x_val[19:0];
                    sum_next   = $signed(33'(Q30_ONE));
                    term_next  = Q30_ONE;
                    i_next     = IW'(1);
                    state_next = S_EXM;
                end
            end
            S_EXM: state_next = S_EXD;
            S_EXD:
            begin
                t_next     = mul_p[50:20];
                den_next   = 6'(i_reg);
                dvexp_next = 1'b1;
                state_next = S_DV1;
            end
            S_CLAMP:
            begin
                if (sum_reg[32])
                    p_next = 31'd0;
                else if (sum_reg[31:0] > 32'(Q30_ONE))
                    p_next = Q30_ONE;
                else
                    p_next = sum_reg[30:0];
                cnt_next   = 2'd0;
                state_next = S_ESQ;
            end
            S_ESQ: state_next = S_ESQC;
            S_ESQC:
            begin
                p_next = mul_p[60:30];
                if (cnt_reg == 2'd3)
                begin
                    alpha_next = Q16_ONE - mul_p[60:44];
                    state_next = S_UPD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_ESQ;
                end
            end
            S_UPD: state_next = S_FIN;
            S_FIN:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cur_next       = cur_new;
                    out_data_next  = cur_new;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        dt_reg       <= dt_next;
        neg_reg      <= neg_next;
        t_reg        <= t_next;
        q_reg        <= q_next;
        den_reg      <= den_next;
        dvexp_reg    <= dvexp_next;
        mag_reg      <= mag_next;
        r_reg        <= r_next;
        bit_reg      <= bit_next;
        target_reg   <= target_next;
        y_reg        <= y_next;
        term_reg     <= term_next;
        sum_reg      <= sum_next;
        i_reg        <= i_next;
        p_reg        <= p_next;
        cnt_reg      <= cnt_next;
        alpha_reg    <= alpha_next;
    end

endmodule

`default_nettype wire

### sv/shaped_parameter_smoother_core.sv
// ============================================================================
// shaped_parameter_smoother_core - shaped parameter smoother, top level
// Shapes a tracked sample by a response curve, maps it into a value range
// and moves the kept value toward it by a frame-time dependent step.
// ============================================================================
//  channel   direction  handshake          payload
//  input     in         in_valid/in_stall  sample, delta_time
//  output    out        out_valid/out_stall smoothed_value
//  config    in/out     psel/penable/pready paddr, pwdata, prdata
//
// One request runs its steps in order on the single shared multiplier: a
// divide by thirty for an angle source, the ease or square-root curve, the
// range mapping, EXP_ITERATIONS Taylor terms (16 by default) each with a
// divide, the clamp, the four squarings of the exponential and the update.
// A frame time giving an exponent of sixteen or more skips the exponential.
// Reset clears the kept value and sets the configuration to its defaults; no clearing pass.
// in_stall is high while a request is in work; a finished result waits in
// the output register while out_stall is high and the next request proceeds.
`default_nettype none

module shaped_parameter_smoother_core #(
    parameter int EXP_ITERATIONS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [4:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [sps_pkg::VAL_W-1:0]  sample,
    input  wire logic [sps_pkg::DT_W-1:0]          delta_time,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [sps_pkg::VAL_W-1:0]       smoothed_value
);
    import sps_pkg::*;

    cfg_t                     cfg;
    seq_status_t              status;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    sps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sps_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    sps_seq #(
        .EXP_ITERATIONS (EXP_ITERATIONS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .delta_time     (delta_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .smoothed_value (smoothed_value),
        .mul_a          (mul_a),
        .mul_b          (mul_b),
        .mul_p          (mul_p),
        .status         (status)
    );

    // an accepted request keeps the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> status.busy)
        else $error("sequencer not busy after accepting a request");

    // a new result only appears at the end of work on a request
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in work");

endmodule

`default_nettype wire

### test/tb_top.sv
// ============================================================================
// tb_top - testbench of the shaped parameter smoother core
// Drives requests through the valid/stall channel, predicts each smoothed
// value with a local fixed-point model and checks results in order.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import sps_pkg::*;

    localparam int EXP_TERMS   = 16;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid, in_stall;
    logic signed [VAL_W-1:0] sample;
    logic [DT_W-1:0] delta_time;
    logic out_valid, out_stall;
    logic signed [VAL_W-1:0] smoothed_value;

    shaped_parameter_smoother_core uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample(sample), .delta_time(delta_time),
        .out_valid(out_valid), .out_stall(out_stall),
        .smoothed_value(smoothed_value)
    );

    // predictor copy of configuration and kept value
    cfg_t    cfg_m;
    longint  kept_value;
    logic signed [VAL_W-1:0] expected_values[$];

    int  errors;
    int  cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;

    // stimulus table: sample, dt, typed-in expectation where obvious
    typedef struct {
        logic signed [VAL_W-1:0] smp;
        logic [DT_W-1:0]         dt;
        bit                      has_exp;
        logic signed [VAL_W-1:0] exp_val;
    } stim_row_t;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic longint floor_div_pow2(input longint x, input int k);
        return x >>> k;
    endfunction

    function automatic longint shape_curve(input longint v);
        longint mag, r, m2, root, n;
        mag = (v < 0) ? -v : v;
        if (mag > 16384)
            mag = 16384;
        case (cfg_m.curve_mode)
            CURVE_EASE:
            begin
                m2 = (mag * mag) >> 14;
                r = (m2 * (49152 - 2 * mag)) >> 14;
            end
            CURVE_SQRT:
            begin
                n = mag << 14;
                root = 0;
                for (int b = 14; b >= 0; b--)
                    if (((root | (64'd1 << b)) * (root | (64'd1 << b))) <= n)
                        root = root | (64'd1 << b);
                r = root;
            end
            CURVE_SNAP: r = (mag >= 8192) ? 16384 : 0;
            default:    r = mag;
        endcase
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint exp_neg_q16(input longint x);
        longint sum, term;
        longint unsigned p;
        if (x >= (64'd16 << 16))
            return 0;
        sum = 64'sd1 << 30;
        term = 64'sd1 << 30;
        for (int i = 1; i <= EXP_TERMS; i++)
        begin
            term = ((term * x) >>> 20) / i;
            if (i % 2 == 1)
                sum -= term;
            else
                sum += term;
        end
        if (sum < 0)
            sum = 0;
        if (sum > (64'sd1 << 30))
            sum = 64'sd1 << 30;
        p = sum;
        for (int s = 0; s < 4; s++)
            p = (p * p) >> 30;
        return longint'(p >> 14);
    endfunction

    // next smoothed value for one request; updates the kept value
    function automatic logic signed [VAL_W-1:0] predict_smoothed(
        input logic signed [VAL_W-1:0] smp, input logic [DT_W-1:0] dt);
        longint v, n, unit, target, resp, k, x, alpha;
        logic signed [VAL_W-1:0] trunc;
        v = smp;
        if (cfg_m.angle_source)
            v = v / 30;
        n = shape_curve(v);
        if (cfg_m.inverted)
            n = -n;
        if (cfg_m.unipolar)
            unit = (n < 0) ? 0 : ((n > 16384) ? 16384 : n);
        else
            unit = (n + 16384) >>> 1;
        target = longint'(cfg_m.min_value)
            + floor_div_pow2(unit * (longint'(cfg_m.max_value) - longint'(cfg_m.min_value)), 14);
        resp = 65536 - longint'(cfg_m.smoothing);
        if (resp < 655)
            resp = 655;
        k = 4 * 65536 + 26 * resp;
        x = (longint'(dt) * k) >> 16;
        alpha = 65536 - exp_neg_q16(x);
        if (alpha < 0)
            alpha = 0;
        if (alpha > 65536)
            alpha = 65536;
        kept_value = kept_value + floor_div_pow2((target - kept_value) * alpha, 16);
        trunc = kept_value[VAL_W-1:0];
        kept_value = trunc;
        return trunc;
    endfunction

    // setup cycle, access cycle, then the bus returns to idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_CURVE:    cfg_m.curve_mode   = value[1:0];
            REG_UNIPOLAR: cfg_m.unipolar     = value[0];
            REG_INVERTED: cfg_m.inverted     = value[0];
            REG_ANGLE:    cfg_m.angle_source = value[0];
            REG_MIN:      cfg_m.min_value    = value[VAL_W-1:0];
            REG_MAX:      cfg_m.max_value    = value[VAL_W-1:0];
            REG_SMOOTH:   cfg_m.smoothing    = value[SMOOTH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] cm, input bit uni, input bit inv,
                              input bit ang, input logic [23:0] mn, input logic [23:0] mx,
                              input logic [16:0] sm);
        write_reg(REG_CURVE, {30'd0, cm});
        write_reg(REG_UNIPOLAR, {31'd0, uni});
        write_reg(REG_INVERTED, {31'd0, inv});
        write_reg(REG_ANGLE, {31'd0, ang});
        write_reg(REG_MIN, {{8{mn[23]}}, mn});
        write_reg(REG_MAX, {{8{mx[23]}}, mx});
        write_reg(REG_SMOOTH, {15'd0, sm});
    endtask

    // offer one request and wait for acceptance; predictor runs on acceptance
    // in_valid stays high after acceptance until the next idle or drain
    task automatic send_request(input logic signed [VAL_W-1:0] smp, input logic [DT_W-1:0] dt,
                                input bit has_exp, input logic signed [VAL_W-1:0] exp_val);
        logic signed [VAL_W-1:0] pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        sample     <= smp;
        delta_time <= dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = predict_smoothed(smp, dt);
        if (has_exp && pred !== exp_val)
            report_mismatch("table entry", pred, exp_val);
        expected_values.push_back(has_exp ? exp_val : pred);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    function automatic logic [DT_W-1:0] random_dt();
        case ($urandom_range(3))
            0:       return DT_W'($urandom_range(2000));
            1:       return DT_W'($urandom_range(20000));
            2:       return DT_W'($urandom);
            default: return DT_W'($urandom_range(60000, 1048575));
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] random_sample();
        case ($urandom_range(2))
            0:       return $signed(24'($urandom_range(32768))) - 24'sd16384;
            1:       return $signed(24'($urandom_range(983040))) - 24'sd491520;
            default: return 24'($urandom);
        endcase
    endfunction

    // output side: random stall, checks against the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_values.size() == 0)
                    report_mismatch("unexpected result", smoothed_value, 0);
                else if (smoothed_value !== expected_values[0])
                begin
                    report_mismatch("smoothed_value", smoothed_value, expected_values[0]);
                    void'(expected_values.pop_front());
                end
                else
                    void'(expected_values.pop_front());
            end
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    stim_row_t directed[$];

    initial
    begin
        int phase_items;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; sample = '0; delta_time = '0;
        cfg_m = '{curve_mode: 2'd0, unipolar: 1'b0, inverted: 1'b0, angle_source: 1'b0,
                  min_value: -24'sd491520, max_value: 24'sd491520, smoothing: 17'd22938};
        kept_value = 0;
        rst_n = 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config; huge dt jumps straight to target, smaller dt steps part way
        directed.push_back('{24'sd16384, 20'hFFFFF, 1'b1, 24'sd491520});
        directed.push_back('{-24'sd16384, 20'hFFFFF, 1'b1, -24'sd491520});
        directed.push_back('{24'sd0, 20'hFFFFF, 1'b1, 24'sd0});
        directed.push_back('{24'sh7FFFFF, 20'hFFFFF, 1'b1, 24'sd491520});
        directed.push_back('{24'sh800000, 20'hFFFFF, 1'b1, -24'sd491520});
        directed.push_back('{24'sd8000, 20'd0, 1'b1, -24'sd491520});
        directed.push_back('{24'sd8000, 20'd1, 1'b0, 24'sd0});
        directed.push_back('{24'sd12000, 20'd3000, 1'b0, 24'sd0});
        directed.push_back('{-24'sd5000, 20'd65536, 1'b0, 24'sd0});
        foreach (directed[i])
            send_request(directed[i].smp, directed[i].dt, directed[i].has_exp,
                         directed[i].exp_val);
        drain_results();

        // every curve, inverted unipolar, angle source, saturated smoothing
        for (int cm = 0; cm < 4; cm++)
        begin
            set_config(cm[1:0], cm[0], cm[1], 1'b1, 24'h800000, 24'h7FFFFF,
                       (cm == 3) ? 17'd65536 : 17'd0);
            send_request(24'sd245760, 20'd1000, 1'b0, 24'sd0);
            send_request(-24'sd491520, 20'd30000, 1'b0, 24'sd0);
            send_request(24'sd122880, 20'hFFFFF, 1'b0, 24'sd0);
            send_request(24'sh7FFFFF, 20'd500, 1'b0, 24'sd0);
            drain_results();
        end

        // random phases with different idling and config
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            set_config(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       24'($urandom), 24'($urandom),
                       (ph == 5) ? 17'd65536 : 17'($urandom_range(65536)));
            if (ph == 4)
            begin
                // long receiver hold-off while requests keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000)
                            @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            phase_items = 235;
            for (int i = 0; i < phase_items; i++)
            begin
                send_request(random_sample(), random_dt(), 1'b0, 24'sd0);
                if (ph == 6 && i == 100)
                begin
                    in_valid <= 1'b0;
                    while (expected_values.size() != 0)
                        @(posedge clk);
                end
            end
            drain_results();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
